// File: hdl/tbc_pkg.sv
// ----------------------------------------------------------------------------
// tbc_pkg
// Shared constants for the barycentric weight pipeline: output width and the
// saturation bounds of the weight fields.
// ----------------------------------------------------------------------------
package tbc_pkg;

    localparam int OUT_W = 32;

    localparam logic signed [OUT_W-1:0] W_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] W_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

// File: hdl/tbc_dot.sv
// ----------------------------------------------------------------------------
// tbc_dot
// Edge vectors and the five dot products, three register stages:
// differences, 15 products, sums of three.
// ----------------------------------------------------------------------------
module tbc_dot #(
    parameter int CW = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [CW-1:0]   v0 [3],
    input  logic signed [CW-1:0]   v1 [3],
    input  logic signed [CW-1:0]   v2 [3],
    input  logic signed [CW-1:0]   pt [3],
    output logic                   out_valid,
    output logic signed [2*CW+3:0] dots [5]
);
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 2;

    logic                 vld1_reg, vld2_reg, vld3_reg;
    logic signed [DW-1:0] e0_reg [3];
    logic signed [DW-1:0] e1_reg [3];
    logic signed [DW-1:0] q_reg  [3];
    logic signed [DW-1:0] pa [15];
    logic signed [DW-1:0] pb [15];
    logic signed [PW-1:0] prod_reg [15];
    logic signed [PW-1:0] prod_next [15];
    logic signed [SW-1:0] sum_reg [5];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pa[i]      = e0_reg[i];
            pb[i]      = e0_reg[i];
            pa[3 + i]  = e0_reg[i];
            pb[3 + i]  = e1_reg[i];
            pa[6 + i]  = e1_reg[i];
            pb[6 + i]  = e1_reg[i];
            pa[9 + i]  = q_reg[i];
            pb[9 + i]  = e0_reg[i];
            pa[12 + i] = q_reg[i];
            pb[12 + i] = e1_reg[i];
        end
        for (int k = 0; k < 15; k++)
        begin
            prod_next[k] = PW'(pa[k]) * PW'(pb[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e0_reg[i] <= DW'(v1[i]) - DW'(v0[i]);
                e1_reg[i] <= DW'(v2[i]) - DW'(v0[i]);
                q_reg[i]  <= DW'(pt[i]) - DW'(v0[i]);
            end
            for (int k = 0; k < 15; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
            for (int j = 0; j < 5; j++)
            begin
                sum_reg[j] <= SW'(prod_reg[3*j]) + SW'(prod_reg[3*j + 1])
                            + SW'(prod_reg[3*j + 2]);
            end
        end
    end

    assign out_valid = vld3_reg;
    assign dots      = sum_reg;

endmodule

// File: hdl/tbc_gram.sv
// ----------------------------------------------------------------------------
// tbc_gram
// Gram determinant and the two Cramer numerators. Each wide product is split
// into half-width partial products, then combined, then differenced.
// ----------------------------------------------------------------------------
module tbc_gram #(
    parameter int SW = 52
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [SW-1:0]  dots [5],
    output logic                  out_valid,
    output logic signed [2*SW:0]  det,
    output logic signed [2*SW:0]  num_v,
    output logic signed [2*SW:0]  num_w
);
    localparam int L   = SW / 2;
    localparam int HW  = SW - L;
    localparam int PW2 = 2 * SW;
    localparam int GW  = PW2 + 1;

    logic                          vld1_reg, vld2_reg, vld3_reg;
    logic signed [SW-1:0]          opa [6];
    logic signed [SW-1:0]          opb [6];
    logic signed [2*HW-1:0]        hh_reg [6];
    logic signed [HW+L:0]          hl_reg [6];
    logic signed [HW+L:0]          lh_reg [6];
    logic        [2*L-1:0]         ll_reg [6];
    logic signed [PW2-1:0]         prod_reg [6];
    logic signed [GW-1:0]          det_reg, nv_reg, nw_reg;

    // pairs: d00*d11, d01*d01, d11*d20, d01*d21, d00*d21, d01*d20
    always_comb
    begin
        opa[0] = dots[0]; opb[0] = dots[2];
        opa[1] = dots[1]; opb[1] = dots[1];
        opa[2] = dots[2]; opb[2] = dots[3];
        opa[3] = dots[1]; opb[3] = dots[4];
        opa[4] = dots[0]; opb[4] = dots[4];
        opa[5] = dots[1]; opb[5] = dots[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int m = 0; m < 6; m++)
            begin
                hh_reg[m] <= $signed(opa[m][SW-1:L]) * $signed(opb[m][SW-1:L]);
                hl_reg[m] <= $signed(opa[m][SW-1:L]) * $signed({1'b0, opb[m][L-1:0]});
                lh_reg[m] <= $signed({1'b0, opa[m][L-1:0]}) * $signed(opb[m][SW-1:L]);
                ll_reg[m] <= opa[m][L-1:0] * opb[m][L-1:0];
                prod_reg[m] <= (PW2'(hh_reg[m]) <<< (2 * L))
                             + ((PW2'(hl_reg[m]) + PW2'(lh_reg[m])) <<< L)
                             + PW2'(ll_reg[m]);
            end
            det_reg <= GW'(prod_reg[0]) - GW'(prod_reg[1]);
            nv_reg  <= GW'(prod_reg[2]) - GW'(prod_reg[3]);
            nw_reg  <= GW'(prod_reg[4]) - GW'(prod_reg[5]);
        end
    end

    assign out_valid = vld3_reg;
    assign det       = det_reg;
    assign num_v     = nv_reg;
    assign num_w     = nw_reg;

endmodule

// File: hdl/tbc_div.sv
// ----------------------------------------------------------------------------
// tbc_div
// Pipelined restoring divider for two numerators over one shared divisor,
// one quotient bit per stage, truncating toward zero. Flags a zero divisor.
// ----------------------------------------------------------------------------
module tbc_div #(
    parameter int GW = 105,
    parameter int WF = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [GW-1:0]  num_a,
    input  logic signed [GW-1:0]  num_b,
    input  logic signed [GW-1:0]  den,
    output logic                  out_valid,
    output logic                  zero,
    output logic signed [GW+WF:0] quo_a,
    output logic signed [GW+WF:0] quo_b
);
    localparam int NW = GW + WF;

    logic          vld_reg  [0:NW];
    logic          sa_reg   [0:NW];
    logic          sb_reg   [0:NW];
    logic          z_reg    [0:NW];
    logic [GW-1:0] d_reg    [0:NW];
    logic [GW-1:0] ra_reg   [0:NW];
    logic [GW-1:0] rb_reg   [0:NW];
    logic [NW-1:0] nqa_reg  [0:NW];
    logic [NW-1:0] nqb_reg  [0:NW];

    logic                  ovld_reg, oz_reg;
    logic signed [NW:0]    qa_reg, qb_reg;
    logic [GW-1:0]         mag_a, mag_b, mag_d;

    always_comb
    begin
        mag_a = num_a[GW-1] ? GW'(-num_a) : GW'(num_a);
        mag_b = num_b[GW-1] ? GW'(-num_b) : GW'(num_b);
        mag_d = den[GW-1]   ? GW'(-den)   : GW'(den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg[0]  <= num_a[GW-1] ^ den[GW-1];
            sb_reg[0]  <= num_b[GW-1] ^ den[GW-1];
            z_reg[0]   <= (den == '0);
            d_reg[0]   <= mag_d;
            ra_reg[0]  <= '0;
            rb_reg[0]  <= '0;
            nqa_reg[0] <= {mag_a, {WF{1'b0}}};
            nqb_reg[0] <= {mag_b, {WF{1'b0}}};
        end
    end

    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        logic [GW-1:0] ta, tb;
        logic          ge_a, ge_b;

        always_comb
        begin
            ta   = {ra_reg[k][GW-2:0], nqa_reg[k][NW-1]};
            tb   = {rb_reg[k][GW-2:0], nqb_reg[k][NW-1]};
            ge_a = (ta >= d_reg[k]);
            ge_b = (tb >= d_reg[k]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sa_reg[k+1]  <= sa_reg[k];
                sb_reg[k+1]  <= sb_reg[k];
                z_reg[k+1]   <= z_reg[k];
                d_reg[k+1]   <= d_reg[k];
                ra_reg[k+1]  <= ge_a ? ta - d_reg[k] : ta;
                rb_reg[k+1]  <= ge_b ? tb - d_reg[k] : tb;
                nqa_reg[k+1] <= {nqa_reg[k][NW-2:0], ge_a};
                nqb_reg[k+1] <= {nqb_reg[k][NW-2:0], ge_b};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovld_reg <= 1'b0;
        end
        else if (en)
        begin
            ovld_reg <= vld_reg[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oz_reg <= z_reg[NW];
            qa_reg <= sa_reg[NW] ? -$signed({1'b0, nqa_reg[NW]}) : $signed({1'b0, nqa_reg[NW]});
            qb_reg <= sb_reg[NW] ? -$signed({1'b0, nqb_reg[NW]}) : $signed({1'b0, nqb_reg[NW]});
        end
    end

    assign out_valid = ovld_reg;
    assign zero      = oz_reg;
    assign quo_a     = qa_reg;
    assign quo_b     = qb_reg;

endmodule

// File: hdl/triangle_barycentric_coords.sv
// ----------------------------------------------------------------------------
// triangle_barycentric_coords
// Barycentric weights (1-v-w, v) of a point against a triangle by Cramer's
// rule, signed Q15.16 saturated outputs with degenerate and clip flags.
//
// Usage:
//   Input channel item_valid/item_stall carries three vertices and a point.
//   Output channel result_valid/result_stall carries the two weights and the
//   degenerate and saturated flags, one result per item, in order.
//   The pipeline has 3 dot-product stages, 3 determinant stages, one divider
//   stage per quotient bit plus sign stages, and one output stage. The
//   divider bit chain sets the latency; throughput is one item per cycle
//   while the output is not stalled. A stall on the output while
//   result_valid is high freezes the whole pipeline, bubbles included, and
//   raises item_stall in the same cycle; nothing is dropped or repeated.
//   Reset clears all valid bits; no item is held across reset.
// ----------------------------------------------------------------------------
module triangle_barycentric_coords #(
    parameter int COORD_WIDTH      = 24,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic signed [COORD_WIDTH-1:0]     vertex0_x,
    input  logic signed [COORD_WIDTH-1:0]     vertex0_y,
    input  logic signed [COORD_WIDTH-1:0]     vertex0_z,
    input  logic signed [COORD_WIDTH-1:0]     vertex1_x,
    input  logic signed [COORD_WIDTH-1:0]     vertex1_y,
    input  logic signed [COORD_WIDTH-1:0]     vertex1_z,
    input  logic signed [COORD_WIDTH-1:0]     vertex2_x,
    input  logic signed [COORD_WIDTH-1:0]     vertex2_y,
    input  logic signed [COORD_WIDTH-1:0]     vertex2_z,
    input  logic signed [COORD_WIDTH-1:0]     point_x,
    input  logic signed [COORD_WIDTH-1:0]     point_y,
    input  logic signed [COORD_WIDTH-1:0]     point_z,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic signed [tbc_pkg::OUT_W-1:0]  weight_first,
    output logic signed [tbc_pkg::OUT_W-1:0]  weight_second,
    output logic                              degenerate,
    output logic                              saturated
);
    import tbc_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int SW = 2 * DW + 2;
    localparam int GW = 2 * SW + 1;
    localparam int NW = GW + WEIGHT_FRAC_BITS;
    localparam int UW = NW + 3;

    localparam logic signed [UW-1:0] ONE  = UW'(1) <<< WEIGHT_FRAC_BITS;
    localparam logic signed [UW-1:0] XMAX = UW'(W_MAX);
    localparam logic signed [UW-1:0] XMIN = UW'(W_MIN);

    logic                      en;
    logic signed [COORD_WIDTH-1:0] v0 [3];
    logic signed [COORD_WIDTH-1:0] v1 [3];
    logic signed [COORD_WIDTH-1:0] v2 [3];
    logic signed [COORD_WIDTH-1:0] pt [3];
    logic                      dot_valid, gram_valid, div_valid, div_zero;
    logic signed [SW-1:0]      dots [5];
    logic signed [GW-1:0]      det, num_v, num_w;
    logic signed [NW:0]        quo_v, quo_w;
    logic signed [UW-1:0]      u_full, v_full;
    logic                      clip_u, clip_v;

    logic                      valid_reg;
    logic signed [OUT_W-1:0]   wf_reg, wf_next, ws_reg, ws_next;
    logic                      degen_reg, sat_reg;

    assign en         = !valid_reg || !result_stall;
    assign item_stall = !en;

    assign v0[0] = vertex0_x; assign v0[1] = vertex0_y; assign v0[2] = vertex0_z;
    assign v1[0] = vertex1_x; assign v1[1] = vertex1_y; assign v1[2] = vertex1_z;
    assign v2[0] = vertex2_x; assign v2[1] = vertex2_y; assign v2[2] = vertex2_z;
    assign pt[0] = point_x;   assign pt[1] = point_y;   assign pt[2] = point_z;

    tbc_dot #(.CW(COORD_WIDTH)) u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (item_valid),
        .v0        (v0),
        .v1        (v1),
        .v2        (v2),
        .pt        (pt),
        .out_valid (dot_valid),
        .dots      (dots)
    );

    tbc_gram #(.SW(SW)) u_gram (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dot_valid),
        .dots      (dots),
        .out_valid (gram_valid),
        .det       (det),
        .num_v     (num_v),
        .num_w     (num_w)
    );

    tbc_div #(.GW(GW), .WF(WEIGHT_FRAC_BITS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (gram_valid),
        .num_a     (num_v),
        .num_b     (num_w),
        .den       (det),
        .out_valid (div_valid),
        .zero      (div_zero),
        .quo_a     (quo_v),
        .quo_b     (quo_w)
    );

    always_comb
    begin
        v_full = UW'(quo_v);
        u_full = ONE - UW'(quo_v) - UW'(quo_w);
        clip_u = (u_full > XMAX) || (u_full < XMIN);
        clip_v = (v_full > XMAX) || (v_full < XMIN);
        if (clip_u)
        begin
            wf_next = u_full[UW-1] ? W_MIN : W_MAX;
        end
        else
        begin
            wf_next = u_full[OUT_W-1:0];
        end
        if (clip_v)
        begin
            ws_next = v_full[UW-1] ? W_MIN : W_MAX;
        end
        else
        begin
            ws_next = v_full[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            degen_reg <= div_zero;
            wf_reg    <= div_zero ? '0 : wf_next;
            ws_reg    <= div_zero ? '0 : ws_next;
            sat_reg   <= !div_zero && (clip_u || clip_v);
        end
    end

    assign result_valid  = valid_reg;
    assign weight_first  = wf_reg;
    assign weight_second = ws_reg;
    assign degenerate    = degen_reg;
    assign saturated     = sat_reg;

`ifndef SYNTH
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && degenerate |->
            weight_first == '0 && weight_second == '0 && !saturated)
        else $error("degenerate result with nonzero weights");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && saturated |->
            weight_first == W_MAX || weight_first == W_MIN ||
            weight_second == W_MAX || weight_second == W_MIN)
        else $error("saturated result without a clipped weight");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled while output free");
`endif

endmodule
